// ===== design/slsn_pkg.sv =====
// Shared types, character codes and helper functions for the line splice normaliser.
package slsn_pkg;

  localparam int unsigned CountW  = 25;
  localparam int unsigned MaxRecs = 4;

  localparam logic [CountW-1:0] FieldMax = {CountW{1'b1}};

  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChCr        = 8'h0D;
  localparam logic [7:0] ChLf        = 8'h0A;
  localparam logic [7:0] ChVt        = 8'h0B;
  localparam logic [7:0] ChFf        = 8'h0C;

  localparam logic [1:0] PendNone    = 2'd0;
  localparam logic [1:0] PendBsl     = 2'd1;
  localparam logic [1:0] PendSwallow = 2'd2;

  typedef enum logic [1:0] {
    KindByte = 2'd0,
    KindSpan = 2'd1,
    KindEnd  = 2'd2
  } kind_e;

  typedef struct packed {
    logic [7:0] src_byte;
    logic       is_final;
  } in_t;

  typedef struct packed {
    kind_e             kind;
    logic [7:0]        out_byte;
    logic [CountW-1:0] out_offset;
    logic [CountW-1:0] line_no;
    logic [CountW-1:0] col_no;
    logic              last;
  } out_t;

  typedef struct packed {
    logic [2:0]              count;
    out_t [MaxRecs-1:0]      recs;
  } bundle_t;

  function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] v,
                                                input logic [CountW-1:0] cap);
    return (v < cap) ? v + 1'b1 : v;
  endfunction

  function automatic out_t mk_rec(input kind_e k, input logic [7:0] b,
                                  input logic [CountW-1:0] off,
                                  input logic [CountW-1:0] ln,
                                  input logic [CountW-1:0] cl);
    out_t r;
    r.kind       = k;
    r.out_byte   = b;
    r.out_offset = off;
    r.line_no    = ln;
    r.col_no     = cl;
    r.last       = 1'b0;
    return r;
  endfunction

endpackage

// ===== design/slsn_front.sv =====
// Front end: accepts source words, tracks splice state and builds a bundle of result records.
module slsn_front import slsn_pkg::*; #(
  parameter longint unsigned MaxSourceBytes = 64'd16777216
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  in_t     in_i,
  output logic    push_o,
  output bundle_t bundle_o,
  input  logic    push_ready_i
);

  localparam logic [CountW-1:0] CountCap =
    (MaxSourceBytes < longint'(FieldMax)) ? CountW'(MaxSourceBytes) : FieldMax;

  logic [1:0]        pend_q, pend_d;
  logic [CountW-1:0] wo_q, wo_d, ln_q, ln_d, cl_q, cl_d;
  logic              started_q;
  logic              accept;

  always_comb begin
    logic [2:0]         n;
    out_t [MaxRecs-1:0] recs;
    logic               do_plain;
    logic [7:0]         b;
    n        = '0;
    recs     = '0;
    do_plain = 1'b0;
    b        = in_i.src_byte;
    wo_d     = wo_q;
    ln_d     = ln_q;
    cl_d     = cl_q;
    pend_d   = PendNone;

    if (!started_q) begin
      recs[n[1:0]] = mk_rec(KindSpan, 8'd0, wo_d, ln_d, cl_d);
      n = n + 3'd1;
    end

    case (pend_q)
      PendBsl: begin
        if (b == ChLf || b == ChCr) begin
          ln_d = sat_inc(ln_d, CountCap);
          cl_d = CountW'(1);
          recs[n[1:0]] = mk_rec(KindSpan, 8'd0, wo_d, ln_d, cl_d);
          n = n + 3'd1;
          if (b == ChCr) begin
            pend_d = PendSwallow;
          end
        end else begin
          recs[n[1:0]] = mk_rec(KindByte, ChBackslash, '0, '0, '0);
          n = n + 3'd1;
          wo_d = sat_inc(wo_d, CountCap);
          cl_d = sat_inc(cl_d, CountCap);
          do_plain = 1'b1;
        end
      end
      PendSwallow: do_plain = (b != ChLf);
      default:     do_plain = 1'b1;
    endcase

    if (do_plain) begin
      if (b == ChBackslash) begin
        pend_d = PendBsl;
      end else if (b == ChCr || b == ChLf) begin
        recs[n[1:0]] = mk_rec(KindByte, ChLf, '0, '0, '0);
        n = n + 3'd1;
        wo_d = sat_inc(wo_d, CountCap);
        ln_d = sat_inc(ln_d, CountCap);
        cl_d = CountW'(1);
        recs[n[1:0]] = mk_rec(KindSpan, 8'd0, wo_d, ln_d, cl_d);
        n = n + 3'd1;
        if (b == ChCr) begin
          pend_d = PendSwallow;
        end
      end else if (b == ChVt || b == ChFf) begin
        cl_d = sat_inc(cl_d, CountCap);
      end else begin
        recs[n[1:0]] = mk_rec(KindByte, b, '0, '0, '0);
        n = n + 3'd1;
        wo_d = sat_inc(wo_d, CountCap);
        cl_d = sat_inc(cl_d, CountCap);
      end
    end

    if (in_i.is_final) begin
      if (pend_d == PendBsl) begin
        recs[n[1:0]] = mk_rec(KindByte, ChBackslash, '0, '0, '0);
        n = n + 3'd1;
        wo_d = sat_inc(wo_d, CountCap);
        cl_d = sat_inc(cl_d, CountCap);
      end
      recs[n[1:0]] = mk_rec(KindEnd, 8'd0, wo_d, '0, '0);
      n = n + 3'd1;
    end

    if (n != 3'd0) begin
      recs[n[1:0] - 2'd1].last = 1'b1;
    end

    bundle_o.count = n;
    bundle_o.recs  = recs;
  end

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept && (bundle_o.count != 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q    <= PendNone;
      wo_q      <= '0;
      ln_q      <= CountW'(1);
      cl_q      <= CountW'(1);
      started_q <= 1'b0;
    end else if (accept) begin
      if (in_i.is_final) begin
        pend_q    <= PendNone;
        wo_q      <= '0;
        ln_q      <= CountW'(1);
        cl_q      <= CountW'(1);
        started_q <= 1'b0;
      end else begin
        pend_q    <= pend_d;
        wo_q      <= wo_d;
        ln_q      <= ln_d;
        cl_q      <= cl_d;
        started_q <= 1'b1;
      end
    end
  end

endmodule

// ===== design/slsn_fifo.sv =====
// Two-entry queue of record bundles between the front and back ends.
module slsn_fifo import slsn_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  bundle_t push_data_i,
  output logic    push_ready_o,
  output logic    head_valid_o,
  output bundle_t head_o,
  input  logic    pop_i
);

  bundle_t    mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = mem_q[rptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wptr_q <= ~wptr_q;
      end
      if (do_pop) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// ===== design/slsn_back.sv =====
// Back end: steps through the records of the head bundle, one output word per cycle while out_ready_i is high.
module slsn_back import slsn_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    head_valid_i,
  input  bundle_t head_i,
  output logic    pop_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output out_t    out_o
);

  logic [1:0] idx_q, idx_d;
  logic       accept;

  assign out_valid_o = head_valid_i;
  assign out_o       = head_i.recs[idx_q];
  assign accept      = out_valid_o && out_ready_i;
  assign pop_o       = accept && out_o.last;

  always_comb begin
    idx_d = idx_q;
    if (pop_o) begin
      idx_d = 2'd0;
    end else if (accept) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

// ===== design/source_line_splice_normalizer.sv =====
// Top level of the source line splice normaliser.
//
//   Channel  Direction  Handshake                 Word
//   input    in         in_valid_i / in_ready_o   in_i  (src_byte, is_final)
//   output   out        out_valid_o / out_ready_i out_o (kind .. last)
//
// A source word is taken every cycle while the two-entry bundle queue has room.
// Each word yields zero to four output words, sent one per cycle by the back end
// while out_ready_i is high, so a word with several results can hold up the input
// once the queue fills. A bundle is registered in the queue before it is sent.
// Reset clears the splice state and empties the queue; there is no clearing pass.
// An output stall only stops input once both queue entries are occupied.
module source_line_splice_normalizer import slsn_pkg::*; #(
  parameter longint unsigned MaxSourceBytes = 64'd16777216
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_o
);

  logic    push, push_ready, head_valid, pop;
  bundle_t push_data, head;

  slsn_front #(
    .MaxSourceBytes(MaxSourceBytes)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .push_o      (push),
    .bundle_o    (push_data),
    .push_ready_i(push_ready)
  );

  slsn_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .push_ready_o(push_ready),
    .head_valid_o(head_valid),
    .head_o      (head),
    .pop_i       (pop)
  );

  slsn_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

  a_end_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.kind == KindEnd |-> out_o.last)
    else $error("end record is not the last word of its source word");

  a_byte_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.kind == KindByte |->
      out_o.out_offset == '0 && out_o.line_no == '0 && out_o.col_no == '0)
    else $error("kept byte word carries position data");

  a_span_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.kind == KindSpan |->
      out_o.line_no != '0 && out_o.col_no != '0 && out_o.out_byte == 8'd0)
    else $error("span record with invalid position");

endmodule
